@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is active.
`define STBS_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("stbs assertion failed");

// Implication check whose consequent is sampled in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("stbs assertion failed");

`endif

@@ design/stbs_pkg.sv @@
// Shared types and constants for the sorted table binary search block.
// No dependencies.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned OP_W            = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } search_status_t;

endpackage

@@ design/stbs_table.sv @@
// Element store: one write port, one read port with registered read data.
// Depends on stbs_pkg.
module stbs_table #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [IdxW-1:0]                     wr_addr_i,
  input  logic signed [stbs_pkg::DATA_W-1:0]  wr_data_i,
  input  logic                                rd_en_i,
  input  logic [IdxW-1:0]                     rd_addr_i,
  output logic signed [stbs_pkg::DATA_W-1:0]  rd_data_o
);

  logic signed [stbs_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

@@ design/stbs_search.sv @@
// Search sequencer: halves the interval one probe at a time.
// Depends on stbs_pkg.
module stbs_search #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [stbs_pkg::DATA_W-1:0]  key_i,
  input  logic [CntW-1:0]                     count_i,
  input  logic                                out_free_i,
  output logic                                rd_en_o,
  output logic [IdxW-1:0]                     rd_addr_o,
  input  logic signed [stbs_pkg::DATA_W-1:0]  rd_data_i,
  output stbs_pkg::search_status_t            status_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_COMPARE,
    ST_FINISH
  } state_e;

  state_e                             state_q, state_d;
  logic [CntW-1:0]                    lo_q, lo_d;
  logic [CntW-1:0]                    hi_q, hi_d;
  logic [CntW-1:0]                    mid_q, mid_d;
  logic signed [stbs_pkg::DATA_W-1:0] key_q, key_d;
  logic                               found_q, found_d;
  logic [CntW:0]                      mid_sum;
  logic [CntW-1:0]                    lo_step, hi_step;

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} - {{CntW{1'b0}}, 1'b1};
  assign rd_en_o   = (state_q == ST_ISSUE);
  assign rd_addr_o = mid_d[IdxW-1:0];

  assign status_o.busy  = (state_q != ST_IDLE);
  assign status_o.done  = (state_q == ST_FINISH);
  assign status_o.found = found_q;

  always_comb begin
    lo_step = lo_q;
    hi_step = hi_q;
    if (rd_data_i > key_q) begin
      hi_step = mid_q;
    end else begin
      lo_step = mid_q + CntW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    key_d   = key_q;
    found_d = found_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          lo_d    = '0;
          hi_d    = count_i;
          found_d = 1'b0;
          state_d = (count_i == '0) ? ST_FINISH : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mid_d   = mid_sum[CntW:1];
        state_d = ST_COMPARE;
      end
      ST_COMPARE: begin
        if (rd_data_i == key_q) begin
          found_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          lo_d    = lo_step;
          hi_d    = hi_step;
          state_d = (lo_step < hi_step) ? ST_ISSUE : ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    key_q <= key_d;
  end

endmodule

@@ design/sorted_table_binary_search.sv @@
// Sorted table with binary search over a single-port-read element store.
// Append and clear do not stall the input and leave the block ready the next cycle.
// A search runs one probe at a time (memory read, then compare) until the key is
// found or the interval is empty; the store's registered read sets the pace.
// Reset clears the element count and the output valid flag; the store is not cleared.
// Depends on stbs_pkg, stbs_table and stbs_search.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [stbs_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [stbs_pkg::DATA_W-1:0]  item_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  stbs_pkg::op_e                      op;
  stbs_pkg::search_status_t           status;
  logic                               in_beat;
  logic                               out_free;
  logic                               wr_en;
  logic                               rd_en;
  logic [IdxW-1:0]                    rd_addr;
  logic signed [stbs_pkg::DATA_W-1:0] rd_data;
  logic [CntW-1:0]                    count_q, count_d;
  logic                               out_valid_q, out_valid_d;
  logic                               found_q, found_d;

  assign op         = stbs_pkg::op_e'(opcode_i);
  assign in_stall_o = status.busy;
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign wr_en      = in_beat && (op == stbs_pkg::OP_APPEND) && (count_q < CntW'(TABLE_DEPTH));

  always_comb begin
    count_d = count_q;
    if (in_beat) begin
      case (op)
        stbs_pkg::OP_APPEND: begin
          if (wr_en) begin
            count_d = count_q + CntW'(1);
          end
        end
        stbs_pkg::OP_CLEAR:  count_d = '0;
        default:             count_d = count_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    if (status.done && out_free) begin
      out_valid_d = 1'b1;
      found_d     = status.found;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

  stbs_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (item_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  stbs_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_beat && (op == stbs_pkg::OP_SEARCH)),
    .key_i      (item_value_i),
    .count_i    (count_q),
    .out_free_i (out_free),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .status_o   (status)
  );

endmodule

@@ design/stbs_checker.sv @@
// Port-level checks for sorted_table_binary_search, bound to the top level.
// Depends on stbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stbs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [stbs_pkg::OP_W-1:0]           opcode_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                found_o
);

  logic in_beat;
  logic search_beat;
  logic other_beat;
  logic out_held;

  assign in_beat      = in_valid_i && !in_stall_o;
  assign search_beat  = in_beat && (opcode_i == stbs_pkg::OP_SEARCH);
  assign other_beat   = in_beat && !search_beat;
  assign out_held     = out_valid_o && out_stall_i;

  `STBS_ASSERT_NEXT(a_search_holds_input, clk_i, rst_ni, search_beat, in_stall_o)
  `STBS_ASSERT_NEXT(a_other_beat_keeps_ready, clk_i, rst_ni, other_beat, !in_stall_o)
  `STBS_ASSERT(a_result_after_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))
  `STBS_ASSERT_NEXT(a_stalled_result_holds, clk_i, rst_ni, out_held, out_valid_o && $stable(found_o))

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .opcode_i     (opcode_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .found_o      (found_o)
);
